@@ src/sse_pkg.sv @@
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types, constants and helpers for the substring search engine.
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int FlagW     = 64;
  localparam int GroupW    = 8;
  localparam int NumGroups = FlagW / GroupW;
  localparam int PosW      = 16;
  localparam int SEndW     = PosW + 2;
  localparam int OffW      = 6;
  localparam int LenW      = 4;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 64;
  localparam int QDepth    = 2;

  localparam logic [OffW-1:0] MaxOffset = 6'd63;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NEEDLE_BYTES  = 3'd0,
    CFG_NEEDLE_LENGTH = 3'd1,
    CFG_IGNORE_CASE   = 3'd2,
    CFG_FIND_LAST     = 3'd3,
    CFG_START_OFFSET  = 3'd4
  } cfg_idx_t;

  // everything the back end needs to finish one text
  typedef struct packed {
    logic                    too_long;
    logic                    find_last;
    logic [OffW-1:0]         offset;
    logic [FlagW-1:0]        flags;
    logic signed [SEndW-1:0] s_end;
    logic                    first_valid;
    logic [PosW-1:0]         first_start;
    logic                    settled_valid;
    logic [PosW-1:0]         settled_start;
  } search_req_t;

  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic ic);
    if (ic && (c >= 8'h41) && (c <= 8'h5A)) begin
      return c + 8'd32;
    end
    return c;
  endfunction

endpackage

@@ src/substring_search_engine_top.sv @@
// ----------------------------------------------------------------------------
// substring_search_engine_top
// Streaming substring search of a text against a configured needle.
// ----------------------------------------------------------------------------
// throughput: one text byte per cycle while in_ready is high, a one-byte text every cycle included
// result path: the request for the last byte of a text passes through the
//   request queue, the flag priority stage and the output register
// a stalled output backs up through a two-entry request queue into in_ready
// reset is synchronous: configuration registers and stream state go to zero, but the byte window is not reset
module substring_search_engine_top
  import sse_pkg::*;
#(
  parameter int MAX_NEEDLE = 8,
  parameter int MAX_TEXT   = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_text_byte,
  input  logic                in_last_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_found,
  output logic [PosW-1:0]     out_match_position,
  output logic                out_too_long
);

  logic        push;
  search_req_t push_req;
  logic        q_ready;
  logic        pop_valid;
  search_req_t pop_req;
  logic        pop;

  sse_front #(
    .MAX_NEEDLE (MAX_NEEDLE),
    .MAX_TEXT   (MAX_TEXT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_text_byte (in_text_byte),
    .in_last_byte (in_last_byte),
    .q_ready      (q_ready),
    .push         (push),
    .push_req     (push_req)
  );

  sse_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_req  (push_req),
    .q_ready   (q_ready),
    .pop_valid (pop_valid),
    .pop_req   (pop_req),
    .pop       (pop)
  );

  sse_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .pop_valid          (pop_valid),
    .pop_req            (pop_req),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found          (out_found),
    .out_match_position (out_match_position),
    .out_too_long       (out_too_long)
  );

endmodule

@@ src/sse_front.sv @@
// ----------------------------------------------------------------------------
// sse_front
// Holds configuration, compares each byte window against the needle and
// tracks first and settled match starts; hands a request to the queue on the
// last byte of a text.
// ----------------------------------------------------------------------------
module sse_front
  import sse_pkg::*;
#(
  parameter int MAX_NEEDLE = 8,
  parameter int MAX_TEXT   = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_text_byte,
  input  logic                in_last_byte,
  input  logic                q_ready,
  output logic                push,
  output search_req_t         push_req
);

  localparam int CntW  = $clog2(MAX_TEXT + 2);
  localparam int SCurW = ((CntW > 7) ? CntW : 7) + 1;
  localparam int WinB  = MAX_NEEDLE + 1;
  localparam int WIdxW = $clog2(WinB);
  localparam logic [CntW-1:0] TextMax   = CntW'(MAX_TEXT);
  localparam logic [LenW-1:0] NeedleMax = LenW'(MAX_NEEDLE);

  logic [CfgDataW-1:0] needle_r;
  logic [LenW-1:0]     len_r;
  logic                ic_r;
  logic                last_mode_r;
  logic [OffW-1:0]     off_r;

  logic [MAX_NEEDLE*8-1:0] win_r;
  logic [CntW-1:0]         cnt_r, cnt_nxt;
  logic                    fv_r, fv_nxt;
  logic [PosW-1:0]         fs_r, fs_nxt;
  logic [FlagW-1:0]        flags_r, flags_nxt;
  logic                    sv_r, sv_nxt;
  logic [PosW-1:0]         ss_r, ss_nxt;

  logic [WinB*8-1:0]        win_all;
  logic [LenW-1:0]          widx;
  logic [7:0]               nb;
  logic [7:0]               tx;
  logic                     all_eq;
  logic signed [SCurW-1:0]  s_cur;
  logic signed [SCurW-1:0]  s_old;
  logic signed [SCurW-1:0]  s_end;
  logic                     active;
  logic                     len_ok;
  logic                     hit;
  logic                     first_take;
  logic                     settle_take;
  logic                     fire;

  assign in_ready = q_ready;
  assign fire     = in_valid && in_ready;
  assign win_all  = {win_r, in_text_byte};

  // newest byte sits in the low byte of the window
  always_comb begin
    all_eq = 1'b1;
    widx   = '0;
    nb     = '0;
    tx     = '0;
    for (int j = 0; j < MAX_NEEDLE; j++) begin
      widx = len_r - LenW'(1) - LenW'(j);
      nb   = needle_r[8*j +: 8];
      tx   = win_all[8*widx[WIdxW-1:0] +: 8];
      if ((LenW'(j) < len_r) && (fold_char(nb, ic_r) != fold_char(tx, ic_r))) begin
        all_eq = 1'b0;
      end
    end
  end

  assign s_cur  = $signed(SCurW'(cnt_r) + SCurW'(1) - SCurW'(len_r));
  assign s_old  = s_cur - $signed(SCurW'(FlagW));
  assign active = cnt_r < TextMax;
  assign len_ok = (len_r != '0) && (len_r <= NeedleMax) && !s_cur[SCurW-1];
  assign hit    = active && len_ok && all_eq;

  assign first_take  = hit && !fv_r && ($unsigned(s_cur) >= SCurW'(off_r));
  assign settle_take = active && flags_r[FlagW-1] && !s_old[SCurW-1];

  assign fv_nxt    = fv_r || first_take;
  assign fs_nxt    = first_take ? PosW'($unsigned(s_cur)) : fs_r;
  assign sv_nxt    = sv_r || settle_take;
  assign ss_nxt    = settle_take ? PosW'($unsigned(s_old)) : ss_r;
  assign flags_nxt = active ? {flags_r[FlagW-2:0], hit} : flags_r;
  assign cnt_nxt   = (cnt_r <= TextMax) ? (cnt_r + CntW'(1)) : cnt_r;
  assign s_end     = $signed(SCurW'(cnt_nxt) - SCurW'(len_r));

  assign push = fire && in_last_byte;

  always_comb begin
    push_req               = '0;
    push_req.too_long      = cnt_nxt > TextMax;
    push_req.find_last     = last_mode_r;
    push_req.offset        = off_r;
    push_req.flags         = flags_nxt;
    push_req.s_end         = SEndW'(s_end);
    push_req.first_valid   = fv_nxt;
    push_req.first_start   = fs_nxt;
    push_req.settled_valid = sv_nxt;
    push_req.settled_start = ss_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_r    <= '0;
      len_r       <= '0;
      ic_r        <= 1'b0;
      last_mode_r <= 1'b0;
      off_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NEEDLE_BYTES:  needle_r    <= cfg_wdata;
        CFG_NEEDLE_LENGTH: len_r       <= cfg_wdata[LenW-1:0];
        CFG_IGNORE_CASE:   ic_r        <= cfg_wdata[0];
        CFG_FIND_LAST:     last_mode_r <= cfg_wdata[0];
        CFG_START_OFFSET: begin
          off_r <= (cfg_wdata[OffW-1:0] > MaxOffset) ? MaxOffset : cfg_wdata[OffW-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      win_r <= win_all[MAX_NEEDLE*8-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      fv_r    <= 1'b0;
      fs_r    <= '0;
      flags_r <= '0;
      sv_r    <= 1'b0;
      ss_r    <= '0;
    end else if (fire) begin
      if (in_last_byte) begin
        // text done, start the next one clean
        cnt_r   <= '0;
        fv_r    <= 1'b0;
        fs_r    <= '0;
        flags_r <= '0;
        sv_r    <= 1'b0;
        ss_r    <= '0;
      end else begin
        cnt_r   <= cnt_nxt;
        fv_r    <= fv_nxt;
        fs_r    <= fs_nxt;
        flags_r <= flags_nxt;
        sv_r    <= sv_nxt;
        ss_r    <= ss_nxt;
      end
    end
  end

endmodule

@@ src/sse_queue.sv @@
// ----------------------------------------------------------------------------
// sse_queue
// Short request queue between the front and back ends.
// ----------------------------------------------------------------------------
module sse_queue
  import sse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  search_req_t push_req,
  output logic        q_ready,
  output logic        pop_valid,
  output search_req_t pop_req,
  input  logic        pop
);

  localparam int PtrW  = $clog2(QDepth);
  localparam int CntQW = $clog2(QDepth + 1);

  search_req_t      slot_r [QDepth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntQW-1:0] cnt_r;

  assign q_ready   = cnt_r != CntQW'(QDepth);
  assign pop_valid = cnt_r != '0;
  assign pop_req   = slot_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PtrW'(QDepth - 1)) ? '0 : (wr_ptr_r + PtrW'(1));
  assign rd_ptr_nxt = (rd_ptr_r == PtrW'(QDepth - 1)) ? '0 : (rd_ptr_r + PtrW'(1));

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CntQW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CntQW'(1);
      end
    end
  end

endmodule

@@ src/sse_back.sv @@
// ----------------------------------------------------------------------------
// sse_back
// Resolves one queued request into a result: a registered two-level priority
// search over the recent match flags, then result select into the output
// register.
// ----------------------------------------------------------------------------
module sse_back
  import sse_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  input  search_req_t     pop_req,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_found,
  output logic [PosW-1:0] out_match_position,
  output logic            out_too_long
);

  localparam int GIdxW = $clog2(GroupW);
  localparam int GrpW  = $clog2(NumGroups);

  logic                 grp_any [NumGroups];
  logic [GIdxW-1:0]     grp_idx [NumGroups];

  logic                 s1_valid_r;
  search_req_t          s1_req_r;
  logic                 s1_any_r [NumGroups];
  logic [GIdxW-1:0]     s1_idx_r [NumGroups];

  logic                 sel_any;
  logic [GrpW-1:0]      sel_grp;
  logic [OffW-1:0]      k_sel;
  logic signed [SEndW-1:0] s_pos;

  logic                 res_found;
  logic [PosW-1:0]      res_pos;
  logic                 res_too_long;

  logic                 out_valid_r;
  logic                 found_r;
  logic [PosW-1:0]      pos_r;
  logic                 too_long_r;

  logic                 adv_out;
  logic                 s1_ready;

  assign adv_out  = !out_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || adv_out;
  assign pop      = pop_valid && s1_ready;

  // per group: lowest flag at or above the offset
  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_any[g] = 1'b0;
      grp_idx[g] = '0;
      for (int b = GroupW - 1; b >= 0; b--) begin
        if (pop_req.flags[g*GroupW + b] &&
            (OffW'(g*GroupW + b) >= pop_req.offset)) begin
          grp_any[g] = 1'b1;
          grp_idx[g] = GIdxW'(b);
        end
      end
    end
  end

  always_comb begin
    sel_any = 1'b0;
    sel_grp = '0;
    for (int g = NumGroups - 1; g >= 0; g--) begin
      if (s1_any_r[g]) begin
        sel_any = 1'b1;
        sel_grp = GrpW'(g);
      end
    end
  end

  assign k_sel = {sel_grp, s1_idx_r[sel_grp]};
  assign s_pos = s1_req_r.s_end - $signed(SEndW'(k_sel));

  always_comb begin
    res_found    = 1'b0;
    res_pos      = '0;
    res_too_long = 1'b0;
    priority if (s1_req_r.too_long) begin
      res_too_long = 1'b1;
    end else if (s1_req_r.find_last) begin
      // a newest flag that starts before the text falls back to the settled start
      if (sel_any && !s_pos[SEndW-1]) begin
        res_found = 1'b1;
        res_pos   = s_pos[PosW-1:0];
      end else if (s1_req_r.settled_valid) begin
        res_found = 1'b1;
        res_pos   = s1_req_r.settled_start;
      end
    end else if (s1_req_r.first_valid) begin
      res_found = 1'b1;
      res_pos   = s1_req_r.first_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= pop_valid;
      end
      if (adv_out) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_req_r <= pop_req;
      for (int g = 0; g < NumGroups; g++) begin
        s1_any_r[g] <= grp_any[g];
        s1_idx_r[g] <= grp_idx[g];
      end
    end
    if (adv_out && s1_valid_r) begin
      found_r    <= res_found;
      pos_r      <= res_pos;
      too_long_r <= res_too_long;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = found_r;
  assign out_match_position = pos_r;
  assign out_too_long       = too_long_r;

endmodule

@@ src/sse_checker.sv @@
// ----------------------------------------------------------------------------
// sse_checker
// Port-level checks for the substring search engine, bound to the top level.
// ----------------------------------------------------------------------------
module sse_checker
  import sse_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [7:0]          in_text_byte,
  input logic                in_last_byte,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_found,
  input logic [PosW-1:0]     out_match_position,
  input logic                out_too_long
);

  // an overlong text never reports a match
  a_too_long_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_too_long))
    else $error("result has both found and too_long");

  // no match means position zero
  a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_match_position == '0))
    else $error("not-found result with nonzero position");

  // reset empties the result side
  a_reset_no_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_found) && $stable(out_match_position) &&
       $stable(out_too_long)))
    else $error("stalled result changed");

  // a waiting request keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=>
      (in_valid && $stable(in_text_byte) && $stable(in_last_byte)))
    else $error("waiting request changed");

endmodule

bind substring_search_engine_top sse_checker u_sse_checker (.*);
